// File: src/assert_macros.svh
// Assertion macros shared by the ring pointer controller modules.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset
`define RPCR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included
`define RPCR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/rpcr_pkg.sv
// Package for the ring pointer claim/commit/rollback controller.
// Holds the command and error codes and the request, result and csr types.
package rpcr_pkg;

   // Widths fixed by the item fields
   localparam int KIND_W  = 4;
   localparam int SLOT_W  = 8;
   localparam int ERR_W   = 2;
   localparam int COUNT_W = 9;
   localparam int CAP_W   = 9;

   localparam int MAX_ENTRIES_DEFAULT = 256;
   localparam int CAP_RESET           = 256;

   // Command kinds
   localparam logic [KIND_W-1:0] KIND_CLAIM_WRITE   = 4'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL_WRITE  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_COMMIT_WRITE  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_CLAIM_READ    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_CANCEL_READ   = 4'd4;
   localparam logic [KIND_W-1:0] KIND_COMPLETE_READ = 4'd5;
   localparam logic [KIND_W-1:0] KIND_COMPLETE_ALL  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_CANCEL_ALL    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_OVERWRITE     = 4'd8;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_REFUSED = 2'd1;
   localparam logic [ERR_W-1:0] ERR_ORDER   = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NOTHING = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              check_enable;
      logic [SLOT_W-1:0] check_slot;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [SLOT_W-1:0]  slot_index;
      logic [ERR_W-1:0]   error_code;
      logic               write_full;
      logic               read_empty;
      logic [COUNT_W-1:0] reads_outstanding;
      logic               overflow_flag;
   } rsp_type;

   // Capacity write toward the pointer engine
   typedef struct packed {
      logic             valid;
      logic [CAP_W-1:0] data;
   } csr_wr_type;

endpackage

// File: src/rpcr_engine.sv
// Pointer state and command logic of the ring pointer controller.
// Depends on rpcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpcr_engine #(
   parameter int MAX_ENTRIES = rpcr_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rpcr_pkg::req_type   cmd,
   input  rpcr_pkg::csr_wr_type csr_wr,
   output rpcr_pkg::rsp_type   result
);

   localparam int OFF_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W   = (OFF_W + 1 > rpcr_pkg::CAP_W + 1) ? OFF_W + 1 : rpcr_pkg::CAP_W + 1;
   localparam int SLOT_W  = rpcr_pkg::SLOT_W;
   localparam int COUNT_W = rpcr_pkg::COUNT_W;
   localparam int RESET_LAST =
      ((rpcr_pkg::CAP_RESET < MAX_ENTRIES) ? rpcr_pkg::CAP_RESET : MAX_ENTRIES) - 1;

   // Pointer: {wrap, offset}
   typedef logic [OFF_W:0] ptr_type;

   ptr_type            mr_ff, mr_in;   // committed read
   ptr_type            mw_ff, mw_in;   // committed write
   ptr_type            cr_ff, cr_in;   // claimed read
   ptr_type            cw_ff, cw_in;   // claimed write
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [OFF_W-1:0]   last_ff, last_in;

   ptr_type            cw_next, cw_prev, mw_next, cr_next, cr_prev, mr_next;
   logic               full_now, empty_now;
   logic               granted;
   logic [SLOT_W-1:0]  slot;
   logic [rpcr_pkg::ERR_W-1:0] err;
   logic [CMP_W-1:0]   cap_ext, cap_clamp;

   function automatic ptr_type ptr_next(input ptr_type p, input logic [OFF_W-1:0] last);
      ptr_type r;
      if (p[OFF_W-1:0] == last) begin
         r = {~p[OFF_W], {OFF_W{1'b0}}};
      end else begin
         r = {p[OFF_W], OFF_W'(p[OFF_W-1:0] + 1'b1)};
      end
      return r;
   endfunction

   function automatic ptr_type ptr_prev(input ptr_type p, input logic [OFF_W-1:0] last);
      ptr_type r;
      if (p[OFF_W-1:0] == '0) begin
         r = {~p[OFF_W], last};
      end else begin
         r = {p[OFF_W], OFF_W'(p[OFF_W-1:0] - 1'b1)};
      end
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input ptr_type p);
      return SLOT_W'(p[OFF_W-1:0]);
   endfunction

   // Neighbor pointers and flags on the current state
   always_comb begin
      cw_next   = ptr_next(cw_ff, last_ff);
      cw_prev   = ptr_prev(cw_ff, last_ff);
      mw_next   = ptr_next(mw_ff, last_ff);
      cr_next   = ptr_next(cr_ff, last_ff);
      cr_prev   = ptr_prev(cr_ff, last_ff);
      mr_next   = ptr_next(mr_ff, last_ff);
      full_now  = (cw_ff == {~mr_ff[OFF_W], mr_ff[OFF_W-1:0]});
      empty_now = (cr_ff == mw_ff);
   end

   // Clamp a written capacity to 1..MAX_ENTRIES
   always_comb begin
      cap_ext = CMP_W'(csr_wr.data);
      if (cap_ext == '0) begin
         cap_clamp = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         cap_clamp = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_clamp = cap_ext;
      end
   end

   // Command decode and next state
   always_comb begin
      mr_in    = mr_ff;
      mw_in    = mw_ff;
      cr_in    = cr_ff;
      cw_in    = cw_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      granted  = 1'b0;
      slot     = '0;
      err      = rpcr_pkg::ERR_NONE;
      case (cmd.kind)
         rpcr_pkg::KIND_CLAIM_WRITE, rpcr_pkg::KIND_OVERWRITE: begin
            if (!full_now) begin
               ovf_in  = 1'b0;
               slot    = slot_of(cw_ff);
               cw_in   = cw_next;
               granted = 1'b1;
            end else if (cmd.kind == rpcr_pkg::KIND_CLAIM_WRITE || mr_ff == mw_ff) begin
               // full, and either no overwrite or nothing readable to drop
               ovf_in = 1'b1;
               err    = rpcr_pkg::ERR_REFUSED;
            end else begin
               // drop the oldest readable slot, then claim
               if (count_ff == '0) begin
                  cr_in = cr_next;
               end else begin
                  count_in = count_ff - 1'b1;
               end
               mr_in   = mr_next;
               ovf_in  = 1'b0;
               slot    = slot_of(cw_ff);
               cw_in   = cw_next;
               granted = 1'b1;
            end
         end
         rpcr_pkg::KIND_CANCEL_WRITE: begin
            if (cw_ff == mw_ff) begin
               err = rpcr_pkg::ERR_NOTHING;
            end else if (cmd.check_enable && cmd.check_slot != slot_of(cw_prev)) begin
               err = rpcr_pkg::ERR_ORDER;
            end else begin
               cw_in   = cw_prev;
               slot    = slot_of(cw_prev);
               granted = 1'b1;
            end
         end
         rpcr_pkg::KIND_COMMIT_WRITE: begin
            if (cw_ff == mw_ff) begin
               err = rpcr_pkg::ERR_NOTHING;
            end else if (cmd.check_enable && cmd.check_slot != slot_of(mw_ff)) begin
               err = rpcr_pkg::ERR_ORDER;
            end else begin
               slot    = slot_of(mw_ff);
               mw_in   = mw_next;
               granted = 1'b1;
            end
         end
         rpcr_pkg::KIND_CLAIM_READ: begin
            if (empty_now) begin
               err = rpcr_pkg::ERR_REFUSED;
            end else begin
               slot     = slot_of(cr_ff);
               cr_in    = cr_next;
               count_in = count_ff + 1'b1;
               granted  = 1'b1;
            end
         end
         rpcr_pkg::KIND_CANCEL_READ: begin
            if (cr_ff == mr_ff) begin
               err = rpcr_pkg::ERR_NOTHING;
            end else if (cmd.check_enable && cmd.check_slot != slot_of(cr_prev)) begin
               err = rpcr_pkg::ERR_ORDER;
            end else begin
               cr_in = cr_prev;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               slot    = slot_of(cr_prev);
               granted = 1'b1;
            end
         end
         rpcr_pkg::KIND_COMPLETE_READ: begin
            if (cr_ff == mr_ff) begin
               err = rpcr_pkg::ERR_NOTHING;
            end else if (cmd.check_enable && cmd.check_slot != slot_of(mr_ff)) begin
               err = rpcr_pkg::ERR_ORDER;
            end else begin
               slot  = slot_of(mr_ff);
               mr_in = mr_next;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               granted = 1'b1;
            end
         end
         rpcr_pkg::KIND_COMPLETE_ALL, rpcr_pkg::KIND_CANCEL_ALL: begin
            if (cr_ff == mr_ff) begin
               err = rpcr_pkg::ERR_NOTHING;
            end else begin
               slot = slot_of(mr_ff);
               if (cmd.kind == rpcr_pkg::KIND_COMPLETE_ALL) begin
                  mr_in = cr_ff;
               end else begin
                  cr_in = mr_ff;
               end
               count_in = '0;
               granted  = 1'b1;
            end
         end
         default: begin
            // unused kinds: no effect
         end
      endcase
   end

   // Result on the post-command state
   always_comb begin
      result.granted           = granted;
      result.slot_index        = slot;
      result.error_code        = err;
      result.write_full        = (cw_in == {~mr_in[OFF_W], mr_in[OFF_W-1:0]});
      result.read_empty        = (cr_in == mw_in);
      result.reads_outstanding = count_in;
      result.overflow_flag     = ovf_in;
   end

   assign last_in = OFF_W'(cap_clamp - CMP_W'(1));

   // State registers; a capacity write clears all pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mr_ff    <= '0;
         mw_ff    <= '0;
         cr_ff    <= '0;
         cw_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= OFF_W'(RESET_LAST);
      end else if (csr_wr.valid) begin
         mr_ff    <= '0;
         mw_ff    <= '0;
         cr_ff    <= '0;
         cw_ff    <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= last_in;
      end else if (fire) begin
         mr_ff    <= mr_in;
         mw_ff    <= mw_in;
         cr_ff    <= cr_in;
         cw_ff    <= cw_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Open read claims exist exactly when claimed read is ahead of committed read
   `RPCR_ASSERT(a_count_matches_ptrs, (cr_ff == mr_ff) == (count_ff == '0),
      "read claim count disagrees with read pointers")
   // Offsets stay inside the active capacity
   `RPCR_ASSERT(a_offsets_in_range,
      mr_ff[OFF_W-1:0] <= last_ff && mw_ff[OFF_W-1:0] <= last_ff &&
      cr_ff[OFF_W-1:0] <= last_ff && cw_ff[OFF_W-1:0] <= last_ff,
      "pointer offset beyond capacity")
   // A capacity write leaves no open claims
   `RPCR_ASSERT(a_csr_clears, csr_wr.valid |=> count_ff == '0 && !ovf_ff && cw_ff == mr_ff,
      "capacity write did not clear state")

endmodule

// File: src/ring_pointer_claim_commit_rollback.sv
// Top level of the ring pointer claim/commit/rollback controller.
// Depends on rpcr_pkg, rpcr_engine and assert_macros.svh.
//
// Usage:
//   req_valid/req_ready/req_data carry one command item (kind, order check).
//   rsp_valid/rsp_ready/rsp_data return exactly one result item per command,
//   in command order: grant, slot, error code, full/empty flags, open read
//   claim count and the overflow mark, all taken after the command.
//   csr_valid/csr_ready/csr_data write the capacity (0 acts as 1, values above
//   MAX_ENTRIES act as MAX_ENTRIES); a write also clears every pointer. csr_ready
//   is always high; write only while no command is in flight.
// Timing:
//   A command is registered on acceptance, evaluated once the result register
//   is free and its result registered there. One command per cycle is sustained
//   while rsp_ready is high; the pointer registers are updated once per command.
// Reset: pointers, claim count and overflow mark clear, capacity returns to
//   256 (clamped to MAX_ENTRIES), both pipeline registers empty.
// Stall: while the result register is full and rsp_ready is low, the input
//   register still takes one more item, then req_ready drops.
`include "assert_macros.svh"

module ring_pointer_claim_commit_rollback #(
   parameter int MAX_ENTRIES = rpcr_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rpcr_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rpcr_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpcr_pkg::CAP_W-1:0]    csr_data
);

   logic                  in_valid_ff, in_valid_in;
   rpcr_pkg::req_type     in_ff;
   logic                  out_valid_ff, out_valid_in;
   rpcr_pkg::rsp_type     out_ff;
   rpcr_pkg::rsp_type     result;
   rpcr_pkg::csr_wr_type  csr_wr;
   logic                  out_free;
   logic                  process;
   logic                  req_fire;

   // Handshake and stage advance
   assign out_free  = !out_valid_ff || rsp_ready;
   assign process   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_wr    = '{valid: csr_valid, data: csr_data};

   assign in_valid_in  = req_fire || (in_valid_ff && !process);
   assign out_valid_in = process || (out_valid_ff && !rsp_ready);

   rpcr_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (process),
      .cmd    (in_ff),
      .csr_wr (csr_wr),
      .result (result)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
      if (process) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A granted command never carries an error
   `RPCR_ASSERT(a_grant_no_error,
      rsp_valid && rsp_data.granted |-> rsp_data.error_code == rpcr_pkg::ERR_NONE,
      "granted item with error code")
   // A refused command reports slot zero
   `RPCR_ASSERT(a_refused_slot_zero,
      rsp_valid && !rsp_data.granted |-> rsp_data.slot_index == '0,
      "refused item with nonzero slot")
   // An item that leaves the input register shows up as a result
   `RPCR_ASSERT(a_advance_gives_result, process |=> rsp_valid,
      "evaluated item missing from result register")
   // Nothing is offered right after reset
   `RPCR_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready,
      "pipeline not empty after reset")

endmodule

// File: tb/rpcr_checker.sv
// Scoreboard for the ring pointer claim/commit/rollback controller.
// Watches the command, result and capacity channels and predicts every result.
// Depends on rpcr_pkg.
`timescale 1ns / 1ps

module rpcr_checker #(
   parameter int MAX_ENTRIES = rpcr_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  rpcr_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rpcr_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [rpcr_pkg::CAP_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending_count
);
   import rpcr_pkg::*;

   // Ring position: slot offset plus wrap bit
   typedef struct packed {
      logic [CAP_W-1:0] off;
      logic             wrap;
   } ring_pos_type;

   // Shadow copy of the pointer state
   logic [CAP_W-1:0]   capacity;
   ring_pos_type       read_done;
   ring_pos_type       write_done;
   ring_pos_type       read_claim;
   ring_pos_type       write_claim;
   logic [COUNT_W-1:0] open_reads;
   logic               overflow_seen;

   rsp_type expected_results[$];
   int      mismatches = 0;
   int      waiting_results = 0;

   assign fail_count    = mismatches;
   assign pending_count = waiting_results;

   function automatic int slots_in_use();
      int c;
      c = int'(capacity);
      if (c == 0) c = 1;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
   endfunction

   function automatic ring_pos_type step_fwd(ring_pos_type x);
      if (int'(x.off) + 1 >= slots_in_use()) begin
         x.off  = '0;
         x.wrap = ~x.wrap;
      end else begin
         x.off = x.off + 1'b1;
      end
      return x;
   endfunction

   function automatic ring_pos_type step_back(ring_pos_type x);
      if (x.off == '0) begin
         x.off  = CAP_W'(slots_in_use() - 1);
         x.wrap = ~x.wrap;
      end else begin
         x.off = x.off - 1'b1;
      end
      return x;
   endfunction

   function automatic logic ring_full();
      return write_claim.off == read_done.off && write_claim.wrap != read_done.wrap;
   endfunction

   function automatic logic ring_empty();
      return read_claim == write_done;
   endfunction

   function automatic void clear_pointers();
      read_done     = '0;
      write_done    = '0;
      read_claim    = '0;
      write_claim   = '0;
      open_reads    = '0;
      overflow_seen = 1'b0;
   endfunction

   // Apply one command to the shadow state and build its result
   task automatic apply_command(input req_type c, output rsp_type r);
      ring_pos_type     p;
      logic             ok;
      logic [CAP_W-1:0] slot;
      logic [ERR_W-1:0] err;
      ok   = 1'b0;
      slot = '0;
      err  = ERR_NONE;
      case (c.kind)
         KIND_CLAIM_WRITE, KIND_OVERWRITE: begin
            if (!ring_full()) begin
               overflow_seen = 1'b0;
               slot          = write_claim.off;
               write_claim   = step_fwd(write_claim);
               ok            = 1'b1;
            end else if (c.kind == KIND_CLAIM_WRITE || read_done == write_done) begin
               overflow_seen = 1'b1;
               err           = ERR_REFUSED;
            end else begin
               // full ring: drop the oldest readable slot, then claim
               if (open_reads == '0) read_claim = step_fwd(read_claim);
               else open_reads = open_reads - 1'b1;
               read_done     = step_fwd(read_done);
               overflow_seen = 1'b0;
               slot          = write_claim.off;
               write_claim   = step_fwd(write_claim);
               ok            = 1'b1;
            end
         end
         KIND_CANCEL_WRITE: begin
            if (write_claim == write_done) begin
               err = ERR_NOTHING;
            end else begin
               p = step_back(write_claim);
               if (c.check_enable && c.check_slot != p.off[SLOT_W-1:0]) begin
                  err = ERR_ORDER;
               end else begin
                  write_claim = p;
                  slot        = p.off;
                  ok          = 1'b1;
               end
            end
         end
         KIND_COMMIT_WRITE: begin
            if (write_claim == write_done) begin
               err = ERR_NOTHING;
            end else if (c.check_enable && c.check_slot != write_done.off[SLOT_W-1:0]) begin
               err = ERR_ORDER;
            end else begin
               slot       = write_done.off;
               write_done = step_fwd(write_done);
               ok         = 1'b1;
            end
         end
         KIND_CLAIM_READ: begin
            if (ring_empty()) begin
               err = ERR_REFUSED;
            end else begin
               slot       = read_claim.off;
               read_claim = step_fwd(read_claim);
               open_reads = open_reads + 1'b1;
               ok         = 1'b1;
            end
         end
         KIND_CANCEL_READ: begin
            if (read_claim == read_done) begin
               err = ERR_NOTHING;
            end else begin
               p = step_back(read_claim);
               if (c.check_enable && c.check_slot != p.off[SLOT_W-1:0]) begin
                  err = ERR_ORDER;
               end else begin
                  read_claim = p;
                  if (open_reads != '0) open_reads = open_reads - 1'b1;
                  slot = p.off;
                  ok   = 1'b1;
               end
            end
         end
         KIND_COMPLETE_READ: begin
            if (read_claim == read_done) begin
               err = ERR_NOTHING;
            end else if (c.check_enable && c.check_slot != read_done.off[SLOT_W-1:0]) begin
               err = ERR_ORDER;
            end else begin
               slot      = read_done.off;
               read_done = step_fwd(read_done);
               if (open_reads != '0) open_reads = open_reads - 1'b1;
               ok = 1'b1;
            end
         end
         KIND_COMPLETE_ALL, KIND_CANCEL_ALL: begin
            if (read_claim == read_done) begin
               err = ERR_NOTHING;
            end else begin
               slot = read_done.off;
               if (c.kind == KIND_COMPLETE_ALL) read_done = read_claim;
               else read_claim = read_done;
               open_reads = '0;
               ok         = 1'b1;
            end
         end
         default: begin
            // unused kinds: no effect, no error
         end
      endcase
      r.granted           = ok;
      r.slot_index        = slot[SLOT_W-1:0];
      r.error_code        = err;
      r.write_full        = ring_full();
      r.read_empty        = ring_empty();
      r.reads_outstanding = open_reads;
      r.overflow_flag     = overflow_seen;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Predict on command accept, compare on result accept
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         capacity = CAP_W'(CAP_RESET);
         clear_pointers();
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_results.size() == 0) begin
               $display("%0t ns: unexpected result item, expected none, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("granted", want.granted, got.granted);
               check_field("slot_index", want.slot_index, got.slot_index);
               check_field("error_code", want.error_code, got.error_code);
               check_field("write_full", want.write_full, got.write_full);
               check_field("read_empty", want.read_empty, got.read_empty);
               check_field("reads_outstanding", want.reads_outstanding,
                           got.reads_outstanding);
               check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
            end
         end
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
            clear_pointers();
         end
         if (req_valid && req_ready) begin
            apply_command(req_data, want);
            expected_results.push_back(want);
         end
      end
      waiting_results <= expected_results.size();
   end

endmodule

// File: tb/testbench.sv
// Top of the ring pointer controller testbench: clock, reset, stimulus, verdict.
// Depends on rpcr_pkg, the ring_pointer_claim_commit_rollback RTL and rpcr_checker.
`timescale 1ns / 1ps

module testbench;
   import rpcr_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_OVERWRITE + 1'b1;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;
   localparam int                STALL_LIMIT      = 1000;
   localparam int                LONG_HOLD        = 60;
   localparam int                PHASE_ITEMS      = 62;
   localparam int                PHASE_CAPS [12]  = '{1, 3, 0, 4, 5, 300, 7, 2, 511, 6, 256, 8};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   int fail_count;
   int pending_count;
   int commands_sent = 0;
   int cur_slots = CAP_RESET;
   int quiet_items = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   ring_pointer_claim_commit_rollback dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   rpcr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic req_type cmd(logic [KIND_W-1:0] kind, logic chk, logic [SLOT_W-1:0] slot);
      req_type c;
      c.kind         = kind;
      c.check_enable = chk;
      c.check_slot   = slot;
      return c;
   endfunction

   // Weighted toward commands that move the pointers
   function automatic req_type random_cmd();
      req_type c;
      int      r;
      r = $urandom_range(0, 99);
      if (r < 18)      c.kind = KIND_CLAIM_WRITE;
      else if (r < 24) c.kind = KIND_CANCEL_WRITE;
      else if (r < 38) c.kind = KIND_COMMIT_WRITE;
      else if (r < 53) c.kind = KIND_CLAIM_READ;
      else if (r < 59) c.kind = KIND_CANCEL_READ;
      else if (r < 73) c.kind = KIND_COMPLETE_READ;
      else if (r < 77) c.kind = KIND_COMPLETE_ALL;
      else if (r < 81) c.kind = KIND_CANCEL_ALL;
      else if (r < 95) c.kind = KIND_OVERWRITE;
      else             c.kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      c.check_enable = 1'($urandom_range(0, 1));
      // guesses within the ring hit the right slot often on small rings
      if ($urandom_range(0, 4) == 0) c.check_slot = SLOT_W'($urandom);
      else c.check_slot = SLOT_W'($urandom_range(0, cur_slots - 1));
      return c;
   endfunction

   // Offer one command item and hold it until accepted
   task automatic send_cmd(input req_type item);
      int gap;
      if (quiet_items > 0) begin
         quiet_items--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) quiet_items = $urandom_range(20, 60);
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      commands_sent++;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_cmd(random_cmd());
   endtask

   // Wait until every result has come back, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (value == '0) cur_slots = 1;
      else if (value > CAP_W'(MAX_ENTRIES_DEFAULT)) cur_slots = MAX_ENTRIES_DEFAULT;
      else cur_slots = int'(value);
   endtask

   // Error paths, full ring and overwrite cases on a two-slot ring
   task automatic run_directed();
      send_cmd(cmd(KIND_CLAIM_READ,    1'b0, 8'd0));
      send_cmd(cmd(KIND_CANCEL_WRITE,  1'b1, 8'd255));
      send_cmd(cmd(KIND_COMMIT_WRITE,  1'b0, 8'd0));
      send_cmd(cmd(KIND_CANCEL_READ,   1'b1, 8'd0));
      send_cmd(cmd(KIND_COMPLETE_READ, 1'b0, 8'd255));
      send_cmd(cmd(KIND_COMPLETE_ALL,  1'b0, 8'd0));
      send_cmd(cmd(KIND_CANCEL_ALL,    1'b1, 8'd255));
      send_cmd(cmd(KIND_SPARE_FIRST,   1'b1, 8'd255));
      send_cmd(cmd(KIND_SPARE_LAST,    1'b0, 8'd0));
      send_cmd(cmd(KIND_CLAIM_WRITE,   1'b0, 8'd0));
      send_cmd(cmd(KIND_CLAIM_WRITE,   1'b1, 8'd255));
      send_cmd(cmd(KIND_CLAIM_WRITE,   1'b0, 8'd0));   // full: refused
      send_cmd(cmd(KIND_OVERWRITE,     1'b0, 8'd0));   // full, nothing committed
      send_cmd(cmd(KIND_CANCEL_WRITE,  1'b1, 8'd0));   // wrong slot
      send_cmd(cmd(KIND_CANCEL_WRITE,  1'b1, 8'd1));
      send_cmd(cmd(KIND_COMMIT_WRITE,  1'b1, 8'd255)); // wrong slot
      send_cmd(cmd(KIND_COMMIT_WRITE,  1'b1, 8'd0));
      send_cmd(cmd(KIND_CLAIM_WRITE,   1'b0, 8'd0));
      send_cmd(cmd(KIND_OVERWRITE,     1'b0, 8'd0));   // full, frees unclaimed slot
      send_cmd(cmd(KIND_COMMIT_WRITE,  1'b0, 8'd0));
      send_cmd(cmd(KIND_CLAIM_READ,    1'b0, 8'd0));
      send_cmd(cmd(KIND_OVERWRITE,     1'b0, 8'd0));   // full, completes open claim
      send_cmd(cmd(KIND_COMMIT_WRITE,  1'b0, 8'd0));
      send_cmd(cmd(KIND_CLAIM_READ,    1'b0, 8'd0));
      send_cmd(cmd(KIND_CANCEL_READ,   1'b1, 8'd255)); // wrong slot
      send_cmd(cmd(KIND_COMPLETE_READ, 1'b1, 8'd0));
      send_cmd(cmd(KIND_COMPLETE_ALL,  1'b0, 8'd0));
   endtask

   // Result side: random stalls, quiet stretches and one long hold-off
   initial begin
      int  gap;
      bit  long_hold_done;
      long_hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && commands_sent >= 150) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap == 0) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: cycles in a row with no handshake on any channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ring_pointer_claim_commit_rollback test failed");
      $finish;
   end

   // Stimulus phases and verdict
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset capacity first
      run_random(60);
      wait_idle();

      write_capacity(CAP_W'(2));
      run_directed();

      foreach (PHASE_CAPS[i]) begin
         wait_idle();
         write_capacity(CAP_W'(PHASE_CAPS[i]));
         if (i == 4) begin
            // sender drains everything mid-phase
            run_random(PHASE_ITEMS / 2);
            wait_idle();
            run_random(PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
      end

      wait_idle();
      write_capacity(CAP_W'($urandom_range(1, 16)));
      run_random(30);

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ring_pointer_claim_commit_rollback test passed");
      else
         $display("ring_pointer_claim_commit_rollback test failed");
      $finish;
   end

endmodule
